// File: src/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// shared defaults and the status word between the merge sequencer and the top
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef struct packed {
    logic busy;  // sequencer is merging
    logic bank;  // bank that holds the current sorted or partly sorted run set
  } msort_stat_t;

endpackage

// File: src/msort_ram.sv
// ----------------------------------------------------------------------------
// msort_ram
// one-write one-read synchronous memory, registered read data
// ----------------------------------------------------------------------------
module msort_ram #(
  parameter int DEPTH = 1024,
  parameter int VW    = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [VW-1:0] rdata
);

  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/msort_merge.sv
// ----------------------------------------------------------------------------
// msort_merge
// bottom-up merge sequencer: reads runs from one bank, writes merged runs to
// the other, swaps banks after each pass
// ----------------------------------------------------------------------------
module msort_merge #(
  parameter int DEPTH = 1024,
  parameter int VW    = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [CW-1:0]        n_in,
  input  logic [VW-1:0]        rdata,
  output logic [AW-1:0]        raddr,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [VW-1:0]        wdata,
  output msort_pkg::msort_stat_t stat
);
  import msort_pkg::*;

  localparam int SW = CW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_LOADL = 3'd2;
  localparam logic [2:0] S_LOADR = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_REFL  = 3'd5;
  localparam logic [2:0] S_REFR  = 3'd6;

  logic [2:0]           state;
  logic                 bank;
  logic [CW-1:0]        n;
  logic [SW-1:0]        w;
  logic [SW-1:0]        lo;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        i;
  logic [CW-1:0]        j;
  logic [CW-1:0]        k;
  logic signed [VW-1:0] head_l;
  logic signed [VW-1:0] head_r;

  logic [SW-1:0] n_w;
  logic [SW-1:0] mid_w;
  logic [SW-1:0] hi_w;
  logic [SW-1:0] w2;
  logic [SW-1:0] lo_step;
  logic          l_ok;
  logic          r_ok;
  logic          take_left;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;

  always_comb begin
    n_w     = SW'(n);
    mid_w   = ((n_w - lo) > w) ? (lo + w) : n_w;
    hi_w    = ((n_w - mid_w) > w) ? (mid_w + w) : n_w;
    w2      = {w[SW-2:0], 1'b0};
    lo_step = lo + w2;
    l_ok    = (i < mid);
    r_ok    = (j < hi);
    // ties go to the left run
    take_left = l_ok && (!r_ok || (head_l <= head_r));
    i_inc   = i + 1'b1;
    j_inc   = j + 1'b1;
  end

  always_comb begin
    case (state)
      S_SETUP: raddr = lo[AW-1:0];
      S_LOADL: raddr = mid[AW-1:0];
      S_MERGE: raddr = take_left ? i_inc[AW-1:0] : j_inc[AW-1:0];
      default: raddr = '0;
    endcase
  end

  assign we    = (state == S_MERGE) && (k != hi);
  assign waddr = k[AW-1:0];
  assign wdata = take_left ? head_l : head_r;

  assign stat.busy = (state != S_IDLE);
  assign stat.bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go) begin
            n    <= n_in;
            bank <= 1'b0;
            w    <= SW'(1);
            lo   <= '0;
            if (n_in > CW'(1)) begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          mid   <= mid_w[CW-1:0];
          hi    <= hi_w[CW-1:0];
          i     <= lo[CW-1:0];
          j     <= mid_w[CW-1:0];
          k     <= lo[CW-1:0];
          state <= S_LOADL;
        end
        S_LOADL: begin
          head_l <= rdata;
          state  <= S_LOADR;
        end
        S_LOADR: begin
          head_r <= rdata;
          state  <= S_MERGE;
        end
        S_MERGE: begin
          if (k == hi) begin
            if (lo_step >= n_w) begin
              // pass done, merged runs now live in the other bank
              bank <= ~bank;
              w    <= w2;
              lo   <= '0;
              state <= (w2 >= n_w) ? S_IDLE : S_SETUP;
            end else begin
              lo    <= lo_step;
              state <= S_SETUP;
            end
          end else begin
            k <= k + 1'b1;
            if (take_left) begin
              i     <= i_inc;
              state <= S_REFL;
            end else begin
              j     <= j_inc;
              state <= S_REFR;
            end
          end
        end
        S_REFL: begin
          head_l <= rdata;
          state  <= S_MERGE;
        end
        S_REFR: begin
          head_r <= rdata;
          state  <= S_MERGE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/merge_sort_engine_core.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_core
// load-then-sort engine for signed words, ascending, stable
// ----------------------------------------------------------------------------
// A load word (kind 0) is written into bank 0 as it is accepted. The load
// with last set starts a bottom-up merge sort over two memory banks that
// ping-pong between passes; busy stays high over ceil(log2 N) passes, whose
// length is set by the single read port of the source bank (each run pair
// opens with the fetch of both run heads, each element takes a read and a
// refill of its run head, and a final step closes each run pair). A read
// word (kind 1) keeps busy high while its read is pending, and its result
// is then registered onto the ports with valid. Results are shown for one
// cycle only and must be taken then; the receiver cannot stall the block.
module merge_sort_engine_core #(
  parameter int DEPTH       = msort_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = msort_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  output logic                          valid,
  output logic signed [VALUE_WIDTH-1:0] sorted_value,
  output logic                          final_res,
  output logic                          empty_res,
  output logic                          overflow
);
  import msort_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    rp;
  logic             sorted;
  logic             ovf;
  logic             rd_pend;
  logic             pend_empty;
  logic             pend_final;

  msort_stat_t      stat;
  logic             accept;
  logic             load_acc;
  logic             read_acc;
  logic [CW-1:0]    base;
  logic             room;
  logic [CW-1:0]    count_next;
  logic             rd_empty;

  logic [AW-1:0]          seq_raddr;
  logic                   seq_we;
  logic [AW-1:0]          seq_waddr;
  logic [VALUE_WIDTH-1:0] seq_wdata;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rd0;
  logic [VALUE_WIDTH-1:0] rd1;
  logic [VALUE_WIDTH-1:0] rd_src;
  logic                   we0;
  logic                   we1;
  logic [AW-1:0]          waddr0;
  logic [VALUE_WIDTH-1:0] wdata0;

  assign busy     = rd_pend | stat.busy;
  assign accept   = start & ~busy;
  assign load_acc = accept & ~kind;
  assign read_acc = accept & kind;

  // a load after a finished sort opens a new set
  always_comb begin
    base       = sorted ? '0 : count;
    room       = (base < CW'(DEPTH));
    count_next = room ? (base + 1'b1) : base;
    rd_empty   = ~sorted || (rp >= count);
  end

  msort_merge #(.DEPTH(DEPTH), .VW(VALUE_WIDTH)) u_merge (
    .clk   (clk),
    .rst   (rst),
    .go    (load_acc & last),
    .n_in  (count_next),
    .rdata (rd_src),
    .raddr (seq_raddr),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .stat  (stat)
  );

  // loads always fill bank 0; the sort starts from bank 0
  always_comb begin
    raddr  = stat.busy ? seq_raddr : rp[AW-1:0];
    we0    = (load_acc & room) | (seq_we & stat.bank);
    waddr0 = stat.busy ? seq_waddr : base[AW-1:0];
    wdata0 = stat.busy ? seq_wdata : value;
    we1    = seq_we & ~stat.bank;
    rd_src = stat.bank ? rd1 : rd0;
  end

  msort_ram #(.DEPTH(DEPTH), .VW(VALUE_WIDTH)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr),
    .rdata (rd0)
  );

  msort_ram #(.DEPTH(DEPTH), .VW(VALUE_WIDTH)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .raddr (raddr),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rp      <= '0;
      sorted  <= 1'b0;
      ovf     <= 1'b0;
      rd_pend <= 1'b0;
      valid   <= 1'b0;
    end else begin
      valid   <= rd_pend;
      rd_pend <= read_acc;
      if (load_acc) begin
        count <= count_next;
        ovf   <= (sorted ? 1'b0 : ovf) | ~room;
        if (last) begin
          sorted <= 1'b1;
          rp     <= '0;
        end else if (sorted) begin
          sorted <= 1'b0;
          rp     <= '0;
        end
      end else if (read_acc && !rd_empty) begin
        rp <= rp + 1'b1;
      end
    end
  end

  // result word payload, memory data lands in the cycle after the read
  always_ff @(posedge clk) begin
    if (read_acc) begin
      pend_empty <= rd_empty;
      pend_final <= ~rd_empty && ((rp + 1'b1) == count);
    end
    if (rd_pend) begin
      sorted_value <= pend_empty ? '0 : rd_src;
      final_res    <= pend_final;
      empty_res    <= pend_empty;
      overflow     <= ovf;
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// load/read word test of merge_sort_engine_core: sets of signed words are
// loaded, sorted by the block and read back; every read is checked field by
// field against a predicted store kept in a small scoreboard
// ----------------------------------------------------------------------------
import msort_pkg::*;

typedef logic signed [VALUE_WIDTH_DEF-1:0] elem_t;

typedef enum logic {
  WORD_LOAD = 1'b0,
  WORD_READ = 1'b1
} word_kind_e;

typedef enum int {
  VAL_ANY,
  VAL_CLOSE,
  VAL_EXTREME
} val_mix_e;

typedef struct packed {
  elem_t val;
  logic  fin;
  logic  emp;
  logic  ovf;
} read_result_t;

class sort_scoreboard;
  elem_t        store [DEPTH_DEF];
  int unsigned  count;
  int unsigned  rd_ptr;
  bit           sorted;
  bit           dropped;
  read_result_t reads_due [$];
  int           errors;

  // stable ascending insertion sort of the loaded set
  function void sort_store();
    elem_t key;
    int    j;
    for (int i = 1; i < count; i++) begin
      key = store[i];
      j = i;
      while (j > 0 && store[j-1] > key) begin
        store[j] = store[j-1];
        j--;
      end
      store[j] = key;
    end
  endfunction

  function void note_word(word_kind_e k, elem_t v, logic l);
    read_result_t r;
    if (k == WORD_LOAD) begin
      // a load after a sort starts a fresh set
      if (sorted) begin
        count   = 0;
        rd_ptr  = 0;
        sorted  = 1'b0;
        dropped = 1'b0;
      end
      if (count < DEPTH_DEF) begin
        store[count] = v;
        count++;
      end else begin
        dropped = 1'b1;
      end
      if (l) begin
        sort_store();
        sorted = 1'b1;
        rd_ptr = 0;
      end
    end else begin
      r.ovf = dropped;
      if (!sorted || rd_ptr >= count) begin
        r.val = '0;
        r.fin = 1'b0;
        r.emp = 1'b1;
      end else begin
        r.val = store[rd_ptr];
        r.fin = (rd_ptr + 1 == count);
        r.emp = 1'b0;
        rd_ptr++;
      end
      reads_due.push_back(r);
    end
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_read(elem_t v, logic f, logic e, logic o);
    read_result_t want;
    if (reads_due.size() == 0) begin
      report_mismatch($sformatf("read result %0d with no read pending", v));
      return;
    end
    want = reads_due.pop_front();
    if (v !== want.val)
      report_mismatch($sformatf("sorted_value %0d, want %0d", v, want.val));
    if (f !== want.fin)
      report_mismatch($sformatf("final_res %b, want %b", f, want.fin));
    if (e !== want.emp)
      report_mismatch($sformatf("empty_res %b, want %b", e, want.emp));
    if (o !== want.ovf)
      report_mismatch($sformatf("overflow %b, want %b", o, want.ovf));
  endtask
endclass

module tb_top;
  localparam int    LIMIT    = 600_000;
  localparam int    N_RANDOM = 700;
  localparam elem_t VMAX     = {1'b0, {(VALUE_WIDTH_DEF-1){1'b1}}};
  localparam elem_t VMIN     = {1'b1, {(VALUE_WIDTH_DEF-1){1'b0}}};

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  logic  kind  = 1'b0;
  elem_t value = '0;
  logic  last  = 1'b0;
  logic  busy;
  logic  valid;
  elem_t sorted_value;
  logic  final_res;
  logic  empty_res;
  logic  overflow;

  sort_scoreboard sb = new;
  int cycles     = 0;
  int words_sent = 0;
  bit no_idle    = 1'b0;

  merge_sort_engine_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .last         (last),
    .valid        (valid),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .empty_res    (empty_res),
    .overflow     (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && valid)
      sb.check_read(sorted_value, final_res, empty_res, overflow);
  end

  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic elem_t pick_value(val_mix_e mix);
    case (mix)
      VAL_CLOSE: return elem_t'(int'($urandom_range(0, 8)) - 4);
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return VMAX;
          1: return VMIN;
          2: return elem_t'(-1);
          3: return '0;
          default: return elem_t'($urandom);
        endcase
      end
      default: return elem_t'($urandom);
    endcase
  endfunction

  task automatic send_word(word_kind_e k, elem_t v, logic l);
    int gap;
    start <= 1'b1;
    kind  <= k;
    value <= v;
    last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(k, v, l);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // value and last are don't-care on a read word, so they are randomized
  task automatic read_word();
    send_word(WORD_READ, elem_t'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // stop sending and wait for every pending read result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.reads_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_set(int n, val_mix_e mix, bit close_set, int n_reads);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4)
        read_word();
      send_word(WORD_LOAD, pick_value(mix), close_set && i == n - 1);
    end
    for (int i = 0; i < n_reads; i++)
      read_word();
  endtask

  initial begin
    int        base;
    int        sets;
    int        n;
    int        n_reads;
    bit        close_set;
    val_mix_e  mix;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // read before anything was sorted
    read_word();
    // extremes and duplicates, then one read past the end
    send_word(WORD_LOAD, VMAX, 1'b0);
    send_word(WORD_LOAD, VMIN, 1'b0);
    send_word(WORD_LOAD, '0, 1'b0);
    send_word(WORD_LOAD, elem_t'(-1), 1'b0);
    send_word(WORD_LOAD, elem_t'(1), 1'b0);
    send_word(WORD_LOAD, VMAX, 1'b0);
    send_word(WORD_LOAD, elem_t'(-1), 1'b1);
    repeat (8) read_word();
    // single-word set
    send_word(WORD_LOAD, elem_t'(5), 1'b1);
    read_word();
    read_word();
    // new set discards the old one; read while the set is still open
    send_word(WORD_LOAD, elem_t'(3), 1'b0);
    read_word();
    send_word(WORD_LOAD, elem_t'(2), 1'b1);
    read_word();
    send_word(WORD_LOAD, VMIN, 1'b1);
    read_word();
    read_word();
    drain();

    // fill past capacity; the closing load itself is dropped
    no_idle = 1'b1;
    for (int i = 0; i < DEPTH_DEF + 3; i++)
      send_word(WORD_LOAD, elem_t'($urandom), i == DEPTH_DEF + 2);
    repeat (DEPTH_DEF + 1) read_word();
    no_idle = 1'b0;

    base = words_sent;
    sets = 0;
    while (words_sent < base + N_RANDOM) begin
      sets++;
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 99)) inside
        [0:69]:  n = $urandom_range(1, 8);
        [70:91]: n = $urandom_range(9, 40);
        default: n = $urandom_range(41, 200);
      endcase
      mix = val_mix_e'($urandom_range(0, 2));
      close_set = ($urandom_range(0, 9) != 0);
      if (!close_set)
        n_reads = $urandom_range(0, 2);
      else if ($urandom_range(0, 4) != 0)
        n_reads = n + $urandom_range(0, 2);
      else
        n_reads = $urandom_range(0, n);
      run_set(n, mix, close_set, n_reads);
      // after the sixth set, hold off until the block has answered every read
      if (sets == 6)
        drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.reads_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: files.f
src/msort_pkg.sv
src/msort_ram.sv
src/msort_merge.sv
src/merge_sort_engine_core.sv
dv/tb_top.sv
